### sv/elr_pkg.sv
// Shared widths, codes and types for the ellipse outline rasterizer.
`default_nettype none

package elr_pkg;

    localparam int DEF_MAX_DIM = 4096;

    localparam int FRAME_W   = 13;
    localparam int CORNER_W  = 13;
    localparam int BOX_W     = 14;
    localparam int COLOR_W   = 32;
    localparam int COORD_W   = 14;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_SQ   = 6'b000010,
        PH_PROD = 6'b000100,
        PH_INIT = 6'b001000,
        PH_ONE  = 6'b010000,
        PH_TWO  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic in_two;
    } t_step_ctl;

    typedef struct packed {
        logic enter_two;
        logic last;
    } t_step_sts;

    typedef struct packed {
        logic                      last_point;
        logic [COLOR_W-1:0]        plot_color;
        logic [MASK_W-1:0]         visible_mask;
        logic signed [COORD_W-1:0] y_upper;
        logic signed [COORD_W-1:0] y_lower;
        logic signed [COORD_W-1:0] x_left;
        logic signed [COORD_W-1:0] x_right;
    } t_result;

endpackage

`default_nettype wire

### sv/elr_step.sv
// One midpoint-ellipse step: point set, clip mask and next walk state.
`default_nettype none

module elr_step
    import elr_pkg::*;
#(
    parameter int HW  = 12,
    parameter int SQW = 24,
    parameter int PW  = 36,
    parameter int DW  = 41,
    parameter int CW  = 15
) (
    input  wire t_step_ctl          i_ctl,
    input  wire logic signed [CW-1:0] i_cx,
    input  wire logic signed [CW-1:0] i_cy,
    input  wire logic [HW-1:0]      i_ox,
    input  wire logic [HW-1:0]      i_oy,
    input  wire logic [PW-1:0]      i_sx,
    input  wire logic [PW-1:0]      i_sy,
    input  wire logic signed [DW-1:0] i_d,
    input  wire logic [SQW-1:0]     i_a2,
    input  wire logic [SQW-1:0]     i_b2,
    input  wire logic [HW-1:0]      i_hx,
    input  wire logic [PW-1:0]      i_b2hx,
    input  wire logic signed [DW-1:0] i_d_two,
    input  wire logic [FRAME_W-1:0] i_fw,
    input  wire logic [FRAME_W-1:0] i_fh,
    output t_result                 o_res,
    output logic [HW-1:0]           o_next_ox,
    output logic [HW-1:0]           o_next_oy,
    output logic [PW-1:0]           o_next_sx,
    output logic [PW-1:0]           o_next_sy,
    output logic signed [DW-1:0]    o_next_d,
    output t_step_sts               o_sts
);

    logic signed [CW-1:0] rx, lx, ly, uy;
    logic [CW-1:0]        fw_ext, fh_ext;
    logic                 rx_in, lx_in, ly_in, uy_in;

    logic [PW-1:0]        a2_p, b2_p;
    logic signed [DW-1:0] a2_d, b2_d, sx_d, sy_d;
    logic signed [DW-1:0] corr, grow;
    logic                 dpos;
    logic [HW-1:0]        ox1, oy1;
    logic [PW-1:0]        sx1, sy1;
    logic                 crossed;

    assign rx = i_cx + $signed({{(CW-HW){1'b0}}, i_ox});
    assign lx = i_cx - $signed({{(CW-HW){1'b0}}, i_ox});
    assign ly = i_cy + $signed({{(CW-HW){1'b0}}, i_oy});
    assign uy = i_cy - $signed({{(CW-HW){1'b0}}, i_oy});

    assign fw_ext = {{(CW-FRAME_W){1'b0}}, i_fw};
    assign fh_ext = {{(CW-FRAME_W){1'b0}}, i_fh};

    assign rx_in = !rx[CW-1] && (rx < fw_ext);
    assign lx_in = !lx[CW-1] && (lx < fw_ext);
    assign ly_in = !ly[CW-1] && (ly < fh_ext);
    assign uy_in = !uy[CW-1] && (uy < fh_ext);

    always_comb begin
        o_res.x_right      = rx[COORD_W-1:0];
        o_res.x_left       = lx[COORD_W-1:0];
        o_res.y_lower      = ly[COORD_W-1:0];
        o_res.y_upper      = uy[COORD_W-1:0];
        o_res.visible_mask = {lx_in && uy_in, rx_in && uy_in, lx_in && ly_in, rx_in && ly_in};
        o_res.plot_color   = '0;
        o_res.last_point   = o_sts.last;
    end

    // The products b2*x and a2*y are carried along as sx and sy, so each
    // step needs only additions.
    assign a2_p = {{(PW-SQW){1'b0}}, i_a2};
    assign b2_p = {{(PW-SQW){1'b0}}, i_b2};
    assign a2_d = $signed({{(DW-SQW){1'b0}}, i_a2});
    assign b2_d = $signed({{(DW-SQW){1'b0}}, i_b2});
    assign sx_d = $signed({{(DW-PW){1'b0}}, i_sx});
    assign sy_d = $signed({{(DW-PW){1'b0}}, i_sy});
    assign dpos = !i_d[DW-1];

    always_comb begin
        if (i_ctl.in_two) begin
            corr = (b2_d <<< 2) - (sx_d <<< 2);
            grow = (sy_d <<< 2) + (a2_d <<< 2) + (a2_d <<< 1);
            ox1  = dpos ? i_ox - 1'b1 : i_ox;
            sx1  = dpos ? i_sx - b2_p : i_sx;
            oy1  = i_oy + 1'b1;
            sy1  = i_sy + a2_p;
            crossed = sy1 > sx1;
        end else begin
            corr = (a2_d <<< 2) - (sy_d <<< 2);
            grow = (sx_d <<< 2) + (b2_d <<< 2) + (b2_d <<< 1);
            oy1  = dpos ? i_oy - 1'b1 : i_oy;
            sy1  = dpos ? i_sy - a2_p : i_sy;
            ox1  = i_ox + 1'b1;
            sx1  = i_sx + b2_p;
            crossed = sx1 > sy1;
        end
    end

    always_comb begin
        o_sts.enter_two = !i_ctl.in_two && crossed;
        o_sts.last      = i_ctl.in_two && crossed;
        if (o_sts.enter_two) begin
            o_next_ox = i_hx;
            o_next_oy = '0;
            o_next_sx = i_b2hx;
            o_next_sy = '0;
            o_next_d  = i_d_two;
        end else begin
            o_next_ox = ox1;
            o_next_oy = oy1;
            o_next_sx = sx1;
            o_next_sy = sy1;
            o_next_d  = i_d + (dpos ? corr : '0) + grow;
        end
    end

endmodule

`default_nettype wire

### sv/ellipse_outline_rasterizer.sv
// Top level of the midpoint ellipse outline rasterizer with stream ports.
//
//  Channel   Direction  Handshake                Carries
//  s         in         i_s_tvalid / o_s_tready  start or step command
//  m         out        o_m_tvalid / i_m_tready  four mirrored points of one step
//  cfg       in         i_cfg_we                 frame width and height
//
// A step transaction can be accepted in every cycle while o_s_tready is high; in a drawing
// phase its point set is registered at the accepting edge, in the output register or skid entry.
// A start transaction with its corner inside the frame is followed by the setup states PH_SQ,
// PH_PROD and PH_INIT (squares, cross products, initial decision terms) with o_s_tready low.
// Reset is synchronous and leaves the block idle with a 4096 by 4096 frame.
// An output register plus one skid entry keep input acceptance running while
// a point set waits on i_m_tready; o_s_tready also falls once the skid is full.
`default_nettype none

module ellipse_outline_rasterizer
    import elr_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // corner_x, corner_y, box_width, box_height, pen_color, zero fill
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // action
    input  wire logic [0:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // x_right, x_left, y_lower, y_upper, visible_mask, plot_color, zero fill
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic                      o_m_tlast,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FRAME_W-1:0]   i_cfg_data
);

    localparam int HALF_MAX = MAX_DIM / 2;
    localparam int HW       = $clog2(HALF_MAX + 1);
    localparam int SQW      = 2 * HW;
    localparam int PW       = 3 * HW;
    localparam int DW       = PW + 5;
    localparam int CW       = $clog2(8192 + MAX_DIM) + 1;

    t_phase r_phase, n_phase;
    logic [FRAME_W-1:0] r_fw, r_fh;

    logic signed [CW-1:0] r_cx, r_cy;
    logic [HW-1:0]        r_hx, r_hy, r_ox, r_oy;
    logic [SQW-1:0]       r_a2, r_b2;
    logic [PW-1:0]        r_sx, r_sy, r_b2hx;
    logic signed [DW-1:0] r_d, r_d_two;
    logic [COLOR_W-1:0]   r_color;

    t_result r_out, r_skd;
    logic    r_out_valid, r_skd_valid;

    logic                        s_fire, m_fire, is_start, is_step, drawing;
    logic                        res_valid, corner_in;
    logic signed [CORNER_W-1:0]  in_cx, in_cy;
    logic signed [BOX_W-1:0]     in_bw, in_bh;
    logic [COLOR_W-1:0]          in_color;
    logic [CORNER_W-1:0]         raw_hx, raw_hy;
    logic [HW-1:0]               hx_c, hy_c;

    t_step_ctl            step_ctl;
    t_step_sts            step_sts;
    t_result              step_res, res_word;
    logic [HW-1:0]        next_ox, next_oy;
    logic [PW-1:0]        next_sx, next_sy;
    logic signed [DW-1:0] next_d;
    logic [PW-1:0]        a2hy_prod, b2hx_prod;
    logic signed [DW-1:0] a2_d, b2_d, sy_d, b2hx_d;

    assign in_cx    = i_s_tdata[12:0];
    assign in_cy    = i_s_tdata[25:13];
    assign in_bw    = i_s_tdata[39:26];
    assign in_bh    = i_s_tdata[53:40];
    assign in_color = i_s_tdata[85:54];

    assign drawing    = (r_phase == PH_ONE) || (r_phase == PH_TWO);
    assign o_s_tready = !r_skd_valid &&
                        (r_phase == PH_IDLE || r_phase == PH_ONE || r_phase == PH_TWO);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign m_fire     = o_m_tvalid && i_m_tready;
    assign is_start   = s_fire && (i_s_tuser[0] == ACT_START);
    assign is_step    = s_fire && (i_s_tuser[0] == ACT_STEP);
    assign res_valid  = is_step && drawing;

    assign corner_in = !in_cx[CORNER_W-1] && ({1'b0, in_cx[CORNER_W-2:0]} < r_fw) &&
                       !in_cy[CORNER_W-1] && ({1'b0, in_cy[CORNER_W-2:0]} < r_fh);

    // Half sizes truncate toward zero, then clamp into [1, MAX_DIM/2].
    assign raw_hx = in_bw[BOX_W-1] ? '0 : in_bw[BOX_W-1:1];
    assign raw_hy = in_bh[BOX_W-1] ? '0 : in_bh[BOX_W-1:1];

    always_comb begin
        if (32'(raw_hx) > 32'(HALF_MAX)) begin
            hx_c = HW'(HALF_MAX);
        end else if (raw_hx == '0) begin
            hx_c = HW'(1);
        end else begin
            hx_c = HW'(raw_hx);
        end
        if (32'(raw_hy) > 32'(HALF_MAX)) begin
            hy_c = HW'(HALF_MAX);
        end else if (raw_hy == '0) begin
            hy_c = HW'(1);
        end else begin
            hy_c = HW'(raw_hy);
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (is_start) begin
            n_phase = corner_in ? PH_SQ : PH_IDLE;
        end else begin
            case (r_phase)
                PH_SQ:   n_phase = PH_PROD;
                PH_PROD: n_phase = PH_INIT;
                PH_INIT: n_phase = PH_ONE;
                PH_ONE: begin
                    if (is_step && step_sts.enter_two) begin
                        n_phase = PH_TWO;
                    end
                end
                PH_TWO: begin
                    if (is_step && step_sts.last) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_IDLE: n_phase = PH_IDLE;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign step_ctl.in_two = (r_phase == PH_TWO);

    elr_step #(
        .HW  (HW),
        .SQW (SQW),
        .PW  (PW),
        .DW  (DW),
        .CW  (CW)
    ) u_step (
        .i_ctl     (step_ctl),
        .i_cx      (r_cx),
        .i_cy      (r_cy),
        .i_ox      (r_ox),
        .i_oy      (r_oy),
        .i_sx      (r_sx),
        .i_sy      (r_sy),
        .i_d       (r_d),
        .i_a2      (r_a2),
        .i_b2      (r_b2),
        .i_hx      (r_hx),
        .i_b2hx    (r_b2hx),
        .i_d_two   (r_d_two),
        .i_fw      (r_fw),
        .i_fh      (r_fh),
        .o_res     (step_res),
        .o_next_ox (next_ox),
        .o_next_oy (next_oy),
        .o_next_sx (next_sx),
        .o_next_sy (next_sy),
        .o_next_d  (next_d),
        .o_sts     (step_sts)
    );

    always_comb begin
        res_word            = step_res;
        res_word.plot_color = r_color;
    end

    assign a2hy_prod = {{HW{1'b0}}, r_a2} * {{(PW-HW){1'b0}}, r_hy};
    assign b2hx_prod = {{HW{1'b0}}, r_b2} * {{(PW-HW){1'b0}}, r_hx};
    assign a2_d      = $signed({{(DW-SQW){1'b0}}, r_a2});
    assign b2_d      = $signed({{(DW-SQW){1'b0}}, r_b2});
    assign sy_d      = $signed({{(DW-PW){1'b0}}, r_sy});
    assign b2hx_d    = $signed({{(DW-PW){1'b0}}, r_b2hx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FRAME_W'(4096);
            r_fh <= FRAME_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Walk state: loaded by a start inside the frame, finished over the setup cycles, then
    // advanced by each step.
    always_ff @(posedge i_clk) begin
        if (is_start && corner_in) begin
            r_hx    <= hx_c;
            r_hy    <= hy_c;
            r_cx    <= $signed({{(CW-CORNER_W){in_cx[CORNER_W-1]}}, in_cx}) +
                       $signed({{(CW-HW){1'b0}}, hx_c});
            r_cy    <= $signed({{(CW-CORNER_W){in_cy[CORNER_W-1]}}, in_cy}) +
                       $signed({{(CW-HW){1'b0}}, hy_c});
            r_ox    <= '0;
            r_oy    <= hy_c;
            r_color <= in_color;
        end else if (r_phase == PH_SQ) begin
            r_a2 <= SQW'(r_hx) * SQW'(r_hx);
            r_b2 <= SQW'(r_hy) * SQW'(r_hy);
        end else if (r_phase == PH_PROD) begin
            r_sy   <= a2hy_prod;
            r_b2hx <= b2hx_prod;
        end else if (r_phase == PH_INIT) begin
            r_sx    <= '0;
            r_d     <= (b2_d <<< 1) + a2_d - (sy_d <<< 1);
            r_d_two <= (a2_d <<< 1) + b2_d - (b2hx_d <<< 1);
        end else if (res_valid) begin
            r_ox <= next_ox;
            r_oy <= next_oy;
            r_sx <= next_sx;
            r_sy <= next_sy;
            r_d  <= next_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || m_fire) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_fire) begin
            r_out <= r_skd_valid ? r_skd : res_word;
        end else if (res_valid) begin
            r_skd <= res_word;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last_point;
    assign o_m_tdata  = {4'b0, r_out.plot_color, r_out.visible_mask, r_out.y_upper,
                         r_out.y_lower, r_out.x_left, r_out.x_right};

    a_skd_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_setup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SQ || r_phase == PH_PROD || r_phase == PH_INIT) |-> !o_s_tready)
        else $error("input accepted during ellipse setup");

    a_setup_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SQ) |=> (r_phase == PH_PROD))
        else $error("setup sequence broken");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && step_sts.last) |=> (r_phase == PH_IDLE))
        else $error("walk continued after final point set");

    a_res_drawing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid) && $past(i_rst_n)) |-> $past(drawing))
        else $error("point set produced outside a drawing phase");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the ellipse outline rasterizer, predicting every point set.
`timescale 1ns / 1ps

module testbench;
    import elr_pkg::*;

    localparam int RUN_LIMIT  = 400000;
    localparam int POINT_BITS = $bits(t_result) - 1;

    typedef struct packed {
        logic                       act;
        logic signed [CORNER_W-1:0] cx;
        logic signed [CORNER_W-1:0] cy;
        logic signed [BOX_W-1:0]    bw;
        logic signed [BOX_W-1:0]    bh;
        logic [COLOR_W-1:0]         color;
    } t_draw_cmd;

    localparam int CMD_BITS = $bits(t_draw_cmd);

    // Tracks the midpoint walk of the current ellipse and holds the point sets still owed.
    class outline_scoreboard;
        longint   frame_w;
        longint   frame_h;
        t_phase   walk;
        longint   ctr_x;
        longint   ctr_y;
        longint   off_x;
        longint   off_y;
        longint   dec;
        longint   a2;
        longint   b2;
        longint   semi_x;
        longint   semi_y;
        logic [COLOR_W-1:0] ink;
        t_result  point_sets_due[$];
        int       errors;

        function new();
            frame_w = 4096;
            frame_h = 4096;
            walk    = PH_IDLE;
            ctr_x   = 0;
            ctr_y   = 0;
            off_x   = 0;
            off_y   = 0;
            dec     = 0;
            a2      = 0;
            b2      = 0;
            semi_x  = 0;
            semi_y  = 0;
            ink     = '0;
            errors  = 0;
        endfunction

        function void set_frame(longint w, longint h);
            frame_w = w;
            frame_h = h;
        endfunction

        function int pending();
            return point_sets_due.size();
        endfunction

        function bit drawing();
            return walk != PH_IDLE;
        endfunction

        function longint axis_sum();
            return semi_x + semi_y;
        endfunction

        function bit in_frame(longint px, longint py);
            return px >= 0 && px < frame_w && py >= 0 && py < frame_h;
        endfunction

        function longint half_axis(longint size);
            longint h;
            h = size > 0 ? size / 2 : 0;
            if (h < 1) h = 1;
            if (h > DEF_MAX_DIM / 2) h = DEF_MAX_DIM / 2;
            return h;
        endfunction

        function void trace_command(t_draw_cmd c);
            longint  cx;
            longint  cy;
            longint  rx;
            longint  lx;
            longint  ly;
            longint  uy;
            t_result r;
            if (c.act == ACT_START) begin
                cx = c.cx;
                cy = c.cy;
                walk = PH_IDLE;
                if (!in_frame(cx, cy)) return;
                semi_x = half_axis(longint'(c.bw));
                semi_y = half_axis(longint'(c.bh));
                ctr_x  = cx + semi_x;
                ctr_y  = cy + semi_y;
                a2     = semi_x * semi_x;
                b2     = semi_y * semi_y;
                off_x  = 0;
                off_y  = semi_y;
                dec    = 2 * b2 + a2 * (1 - 2 * semi_y);
                ink    = c.color;
                walk   = PH_ONE;
                return;
            end
            if (walk == PH_IDLE) return;

            rx = ctr_x + off_x;
            lx = ctr_x - off_x;
            ly = ctr_y + off_y;
            uy = ctr_y - off_y;
            r.x_right      = rx[COORD_W-1:0];
            r.x_left       = lx[COORD_W-1:0];
            r.y_lower      = ly[COORD_W-1:0];
            r.y_upper      = uy[COORD_W-1:0];
            r.visible_mask = {in_frame(lx, uy), in_frame(rx, uy),
                              in_frame(lx, ly), in_frame(rx, ly)};
            r.plot_color   = ink;
            r.last_point   = 1'b0;

            if (walk == PH_ONE) begin
                if (dec >= 0) begin
                    dec += 4 * a2 * (1 - off_y);
                    off_y--;
                end
                dec += b2 * (4 * off_x + 6);
                off_x++;
                // Once the slope passes minus one the walk restarts from the end of the x axis.
                if (!(b2 * off_x <= a2 * off_y)) begin
                    off_x = semi_x;
                    off_y = 0;
                    dec   = 2 * a2 + b2 * (1 - 2 * semi_x);
                    walk  = PH_TWO;
                end
            end else begin
                if (dec >= 0) begin
                    dec += 4 * b2 * (1 - off_x);
                    off_x--;
                end
                dec += a2 * (4 * off_y + 6);
                off_y++;
                if (!(a2 * off_y <= b2 * off_x)) begin
                    r.last_point = 1'b1;
                    walk = PH_IDLE;
                end
            end
            point_sets_due.push_back(r);
        endfunction

        function void check_field(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void match_point_set(t_result got);
            t_result want;
            if (point_sets_due.size() == 0) begin
                $error("point set received with none outstanding");
                errors++;
                return;
            end
            want = point_sets_due.pop_front();
            check_field("x_right", $signed(want.x_right), $signed(got.x_right));
            check_field("x_left", $signed(want.x_left), $signed(got.x_left));
            check_field("y_lower", $signed(want.y_lower), $signed(got.y_lower));
            check_field("y_upper", $signed(want.y_upper), $signed(got.y_upper));
            check_field("visible_mask", want.visible_mask, got.visible_mask);
            check_field("plot_color", want.plot_color, got.plot_color);
            check_field("last_point", want.last_point, got.last_point);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_valid  = 1'b0;
    logic [S_TDATA_W-1:0] s_data   = '0;
    logic [0:0]           s_user   = ACT_START;
    logic                 m_ready  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_FRAME_WIDTH;
    logic [FRAME_W-1:0]   cfg_data = '0;
    wire                  s_ready;
    wire                  m_valid;
    wire [M_TDATA_W-1:0]  m_data;
    wire                  m_last;

    outline_scoreboard sb = new();
    int items_accepted = 0;
    int burst_left     = 0;

    ellipse_outline_rasterizer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tlast  (m_last),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            sb.match_point_set(t_result'({m_last, m_data[POINT_BITS-1:0]}));
        end
    end

    // Offers one command, with a random gap first whenever a burst has run out.
    task automatic push_item(input t_draw_cmd c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= {2'b00, c.color, c.bh, c.bw, c.cy, c.cx};
        s_user  <= c.act;
        do @(posedge clk); while (!s_ready);
        sb.trace_command(c);
        items_accepted++;
    endtask

    task automatic push_step();
        t_draw_cmd c;
        c     = t_draw_cmd'(CMD_BITS'({$urandom, $urandom, $urandom}));
        c.act = ACT_STEP;
        push_item(c);
    endtask

    task automatic push_start(input int cx, input int cy, input int bw, input int bh,
                              input logic [COLOR_W-1:0] color);
        t_draw_cmd c;
        c.act   = ACT_START;
        c.cx    = CORNER_W'(cx);
        c.cy    = CORNER_W'(cy);
        c.bw    = BOX_W'(bw);
        c.bh    = BOX_W'(bh);
        c.color = color;
        push_item(c);
    endtask

    task automatic step_until_done(input int cap);
        int n;
        n = 0;
        while (sb.drawing() && n < cap) begin
            push_step();
            n++;
        end
    endtask

    task automatic settle_outputs();
        @(negedge clk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_frame(input int w, input int h);
        settle_outputs();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_WIDTH;
        cfg_data <= FRAME_W'(w);
        @(negedge clk);
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= FRAME_W'(h);
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_frame(w, h);
    endtask

    function automatic logic signed [BOX_W-1:0] rand_box();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            v = $urandom_range(0, 40);
        end else if (pick < 80) begin
            v = $urandom_range(1, 4096);
            v = -v;
        end else if (pick < 94) begin
            v = $urandom_range(41, 200);
        end else begin
            v = $urandom;
        end
        return BOX_W'(v);
    endfunction

    function automatic int rand_corner(input longint extent);
        longint lim;
        lim = extent < 4096 ? extent : 4096;
        if (lim > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, int'(lim - 1));
        return $urandom;
    endfunction

    task automatic random_phase(input int quota);
        int stop;
        int kind;
        int cap;
        stop = items_accepted + quota;
        while (items_accepted < stop) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                push_step();
            end else if (kind == 1) begin
                push_start($urandom, $urandom, rand_box(), rand_box(), $urandom);
            end else begin
                push_start(rand_corner(sb.frame_w), rand_corner(sb.frame_h),
                           rand_box(), rand_box(), $urandom);
                // Big ellipses are cut short by the next command to keep the run brief.
                if (sb.axis_sum() > 200) cap = $urandom_range(5, 40);
                else if ($urandom_range(0, 9) == 0) cap = $urandom_range(0, 20);
                else cap = 1000;
                step_until_done(cap);
                if ($urandom_range(0, 7) == 0) push_step();
            end
        end
    endtask

    // The receiver cycles through its own stall patterns, with one long hold-off.
    initial begin
        int mode;
        int span;
        int k;
        int n;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held && items_accepted >= 500) begin
                held = 1'b1;
                @(negedge clk);
                m_ready <= 1'b0;
                for (n = 0; n < 400; n++) @(negedge clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 160);
                for (k = 0; k < span; k++) begin
                    @(negedge clk);
                    case (mode)
                        0: begin
                            m_ready <= 1'b1;
                        end
                        1: begin
                            m_ready <= 1'($urandom_range(0, 1));
                        end
                        2: begin
                            m_ready <= (k % 4) != 3;
                        end
                        default: begin
                            m_ready <= (k % 9) < 2;
                        end
                    endcase
                end
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands at the default frame.
        push_step();
        push_start(0, 0, 1, 1, 32'hFFFF_FFFF);
        step_until_done(1000);
        push_start(4095, 4095, 4096, 4096, 32'hA5A5_5A5A);
        step_until_done(3);
        push_start(-4096, -4096, -4096, -4096, 32'h0000_0000);
        push_step();
        push_start(10, 20, -4096, -1, 32'h0000_0000);
        step_until_done(1000);
        push_start(100, 100, 3, 8, 32'h5A5A_A5A5);
        step_until_done(1000);

        random_phase(330);
        write_frame(640, 480);
        random_phase(330);
        write_frame(1, 1);
        random_phase(250);
        write_frame(8191, 8191);
        random_phase(330);
        write_frame(0, 4096);
        random_phase(80);
        write_frame(4096, 0);
        random_phase(60);
        write_frame(37, 4096);
        random_phase(260);
        write_frame(4096, 4096);
        random_phase(280);

        settle_outputs();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
